// ===== rtl/ansi_escape_terminal_parser_top_defines.svh =====
// Assertion macros for the escape parser top level.
`ifndef ANSI_ESCAPE_TERMINAL_PARSER_TOP_DEFINES_SVH
`define ANSI_ESCAPE_TERMINAL_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define AETP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aetp: assertion failed");

// Next-cycle implication, checked on i_clk, off during reset.
`define AETP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aetp: assertion failed");

`endif

// ===== rtl/aetp_pkg.sv =====
// Shared types, constants and SGR helper for the escape parser.
`default_nettype none

package aetp_pkg;

    localparam int MAX_PARAMS_DEF = 16;
    localparam int PARAM_BITS_DEF = 16;

    localparam int CMD_W   = 4;
    localparam int GLYPH_W = 8;
    localparam int COUNT_W = 16;
    localparam int POS_W   = 17;
    localparam int ATTR_W  = 8;
    localparam int CHAR_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT    = 4'd0,
        CMD_NEWLINE  = 4'd1,
        CMD_LEFT     = 4'd2,
        CMD_UP       = 4'd3,
        CMD_DOWN     = 4'd4,
        CMD_RIGHT    = 4'd5,
        CMD_GOTO     = 4'd6,
        CMD_ATTR     = 4'd7,
        CMD_CLR_TO   = 4'd8,
        CMD_CLR_ALL  = 4'd9,
        CMD_CLR_FROM = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic accept;
        logic walk_step;
        logic walk_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic sgr_start;
        logic walk_last;
        logic out_busy;
    } t_dp_status;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_CSI   = 8'h9B;
    localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_DOWN  = 8'h42;
    localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h43;
    localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h44;
    localparam logic [CHAR_W-1:0] CH_HOME  = 8'h48;
    localparam logic [CHAR_W-1:0] CH_HVP   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_ED    = 8'h4A;
    localparam logic [CHAR_W-1:0] CH_SGR   = 8'h6D;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [ATTR_W-1:0] ATTR_BRIGHT  = 8'h08;
    localparam logic [ATTR_W-1:0] ATTR_NOBRITE = 8'h77;
    localparam logic [ATTR_W-1:0] ATTR_KEEP_FG = 8'hF8;
    localparam logic [ATTR_W-1:0] ATTR_KEEP_BG = 8'h8F;
    localparam logic [ATTR_W-1:0] ATTR_LO_NIB  = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_HI_NIB  = 8'hF0;
    localparam logic [ATTR_W-1:0] ATTR_BG_BRT  = 8'h80;

    localparam logic [6:0] SGR_RESET   = 7'd0;
    localparam logic [6:0] SGR_BOLD    = 7'd1;
    localparam logic [6:0] SGR_REVERSE = 7'd7;
    localparam logic [6:0] SGR_NORMAL  = 7'd22;
    localparam logic [6:0] SGR_FG_LO   = 7'd30;
    localparam logic [6:0] SGR_FG_HI   = 7'd37;
    localparam logic [6:0] SGR_FG_DEF  = 7'd39;
    localparam logic [6:0] SGR_BG_LO   = 7'd40;
    localparam logic [6:0] SGR_BG_HI   = 7'd47;
    localparam logic [6:0] SGR_BG_DEF  = 7'd49;
    localparam logic [6:0] SGR_FGB_LO  = 7'd90;
    localparam logic [6:0] SGR_FGB_HI  = 7'd97;
    localparam logic [6:0] SGR_BGB_LO  = 7'd100;
    localparam logic [6:0] SGR_BGB_HI  = 7'd107;

    // low_code: the parameter is below 128, so code holds all of it
    function automatic logic [ATTR_W-1:0] sgr_apply(input logic [ATTR_W-1:0] v,
                                                    input logic low_code,
                                                    input logic [6:0] code);
        logic [ATTR_W-1:0] r;
        r = v;
        if (low_code) begin
            case (code) inside
                SGR_RESET:   r = ATTR_RESET;
                SGR_BOLD:    r = v | ATTR_BRIGHT;
                SGR_REVERSE: r = {v[3:0], v[7:4]};
                SGR_NORMAL:  r = v & ATTR_NOBRITE;
                SGR_FG_DEF:  r = (v & ATTR_KEEP_FG) | ATTR_RESET;
                SGR_BG_DEF:  r = v & ATTR_LO_NIB;
                [SGR_FG_LO:SGR_FG_HI]: begin
                    r = (v & ATTR_KEEP_FG) | {5'b0, 3'(code - SGR_FG_LO)};
                end
                [SGR_BG_LO:SGR_BG_HI]: begin
                    r = (v & ATTR_KEEP_BG) | {1'b0, 3'(code - SGR_BG_LO), 4'b0};
                end
                [SGR_FGB_LO:SGR_FGB_HI]: begin
                    r = (v & ATTR_HI_NIB) | ATTR_BRIGHT | {5'b0, 3'(code - SGR_FGB_LO)};
                end
                [SGR_BGB_LO:SGR_BGB_HI]: begin
                    r = (v & ATTR_LO_NIB) | ATTR_BG_BRT | {1'b0, 3'(code - SGR_BGB_LO), 4'b0};
                end
                default: r = v;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aetp_ctrl.sv =====
// Controller state machine: input handshake, SGR walk and result load.
`default_nettype none

module aetp_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  aetp_pkg::t_dp_status i_status,
    output aetp_pkg::t_dp_cmd    o_cmd
);
    import aetp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_status.out_busy && i_status.sgr_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_status.walk_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.accept      = 1'b0;
        o_cmd.walk_step   = 1'b0;
        o_cmd.walk_finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = !i_status.out_busy;
                o_cmd.accept = i_in_valid && !i_status.out_busy;
            end
            ST_WALK: o_cmd.walk_step = 1'b1;
            ST_EMIT: o_cmd.walk_finish = !i_status.out_busy;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/aetp_dp.sv =====
// Datapath: parse mode, parameter file, attribute and result register.
`default_nettype none

module aetp_dp #(
    parameter int MAX_PARAMS = aetp_pkg::MAX_PARAMS_DEF,
    parameter int PARAM_BITS = aetp_pkg::PARAM_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  aetp_pkg::t_dp_cmd                     i_cmd,
    output aetp_pkg::t_dp_status                  o_status,
    input  wire  [aetp_pkg::CHAR_W-1:0]           i_byte,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output aetp_pkg::t_cmd                        o_command,
    output logic [aetp_pkg::GLYPH_W-1:0]          o_glyph,
    output logic [aetp_pkg::COUNT_W-1:0]          o_count,
    output logic signed [aetp_pkg::POS_W-1:0]     o_column,
    output logic signed [aetp_pkg::POS_W-1:0]     o_row,
    output logic [aetp_pkg::ATTR_W-1:0]           o_attr
);
    import aetp_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PARAMS);
    localparam int PROD_W = PARAM_BITS + 4;
    localparam logic [IDX_W-1:0]      LAST_SLOT = IDX_W'(MAX_PARAMS - 1);
    localparam logic [PARAM_BITS-1:0] PMAX      = {PARAM_BITS{1'b1}};
    localparam logic [PARAM_BITS-1:0] PONE      = PARAM_BITS'(1);
    localparam logic [PARAM_BITS-1:0] PTWO      = PARAM_BITS'(2);

    t_mode                 r_mode, n_mode;
    logic [MAX_PARAMS-1:0] r_given, n_given;
    logic [PARAM_BITS-1:0] r_value [MAX_PARAMS];
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic [IDX_W-1:0]      r_walk, n_walk;
    logic [ATTR_W-1:0]     r_text_attr, n_text_attr;

    logic                      r_out_valid;
    t_cmd                      r_command, n_command;
    logic [GLYPH_W-1:0]        r_glyph, n_glyph;
    logic [COUNT_W-1:0]        r_count, n_count;
    logic signed [POS_W-1:0]   r_column, n_column;
    logic signed [POS_W-1:0]   r_row, n_row;
    logic [ATTR_W-1:0]         r_attr, n_attr;
    logic                      n_load;
    logic                      wr_en;

    logic [IDX_W-1:0]      rd_addr;
    logic [PARAM_BITS-1:0] rd_val;
    logic [PROD_W-1:0]     prod;
    logic [PARAM_BITS-1:0] digit_val;
    logic                  is_digit;
    logic [PARAM_BITS-1:0] p0_or1, p1_or1, p0_or0;
    logic                  out_busy;

    assign rd_addr = i_cmd.walk_step ? r_walk : r_slot;
    assign rd_val  = r_given[rd_addr] ? r_value[rd_addr] : '0;
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign prod = ({4'b0, rd_val} << 3) + ({4'b0, rd_val} << 1)
                + PROD_W'(i_byte - CH_ZERO);
    assign digit_val = (prod > {4'b0, PMAX}) ? PMAX : prod[PARAM_BITS-1:0];

    assign p0_or1 = r_given[0] ? r_value[0] : PONE;
    assign p1_or1 = r_given[1] ? r_value[1] : PONE;
    assign p0_or0 = r_given[0] ? r_value[0] : '0;

    assign out_busy           = r_out_valid && !i_out_ready;
    assign o_status.out_busy  = out_busy;
    assign o_status.walk_last = (r_walk == r_slot);
    assign o_status.sgr_start = (r_mode == MODE_CSI) && (i_byte == CH_SGR);

    always_comb begin
        n_mode      = r_mode;
        n_given     = r_given;
        n_slot      = r_slot;
        n_walk      = r_walk;
        n_text_attr = r_text_attr;
        wr_en       = 1'b0;
        n_load      = 1'b0;
        n_command   = CMD_PRINT;
        n_glyph     = '0;
        n_count     = '0;
        n_column    = '0;
        n_row       = '0;
        n_attr      = '0;

        if (i_cmd.accept) begin
            unique case (r_mode)
                MODE_ESC: begin
                    n_mode = (i_byte == CH_LBRK) ? MODE_CSI : MODE_NORMAL;
                end
                MODE_CSI: begin
                    if (is_digit) begin
                        wr_en           = 1'b1;
                        n_given[r_slot] = 1'b1;
                    end else if (i_byte == CH_SEMI && r_slot != LAST_SLOT) begin
                        n_slot = r_slot + 1'b1;
                    end else begin
                        n_mode = MODE_NORMAL;
                        if (i_byte != CH_SGR) begin
                            n_given = '0;
                            n_slot  = '0;
                        end
                        case (i_byte) inside
                            CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT: begin
                                n_load  = (p0_or1 != '0);
                                n_count = COUNT_W'(p0_or1);
                                case (i_byte)
                                    CH_UP:    n_command = CMD_UP;
                                    CH_DOWN:  n_command = CMD_DOWN;
                                    CH_RIGHT: n_command = CMD_RIGHT;
                                    default:  n_command = CMD_LEFT;
                                endcase
                            end
                            CH_HOME, CH_HVP: begin
                                n_load    = 1'b1;
                                n_command = CMD_GOTO;
                                n_column  = POS_W'(POS_W'(p1_or1) - POS_W'(1));
                                n_row     = POS_W'(POS_W'(p0_or1) - POS_W'(1));
                            end
                            CH_ED: begin
                                n_load = 1'b1;
                                if (p0_or0 == PONE) begin
                                    n_command = CMD_CLR_TO;
                                end else if (p0_or0 == PTWO) begin
                                    n_command = CMD_CLR_ALL;
                                end else begin
                                    n_command = CMD_CLR_FROM;
                                end
                            end
                            default: n_load = 1'b0;
                        endcase
                    end
                end
                default: begin
                    case (i_byte)
                        CH_BS: begin
                            n_load    = 1'b1;
                            n_command = CMD_LEFT;
                            n_count   = COUNT_W'(1);
                        end
                        CH_LF: begin
                            n_load    = 1'b1;
                            n_command = CMD_NEWLINE;
                        end
                        CH_ESC: n_mode = MODE_ESC;
                        CH_CSI: n_mode = MODE_CSI;
                        default: begin
                            n_load    = 1'b1;
                            n_command = CMD_PRINT;
                            n_glyph   = i_byte;
                        end
                    endcase
                end
            endcase
        end

        if (i_cmd.walk_step) begin
            n_text_attr = sgr_apply(r_text_attr, ~|rd_val[PARAM_BITS-1:7], rd_val[6:0]);
            n_walk      = r_walk + 1'b1;
        end

        if (i_cmd.walk_finish) begin
            n_load    = 1'b1;
            n_command = CMD_ATTR;
            n_attr    = r_text_attr;
            n_given   = '0;
            n_slot    = '0;
            n_walk    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_given     <= '0;
            r_slot      <= '0;
            r_walk      <= '0;
            r_text_attr <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_given     <= n_given;
            r_slot      <= n_slot;
            r_walk      <= n_walk;
            r_text_attr <= n_text_attr;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_value[r_slot] <= digit_val;
        end
        if (n_load) begin
            r_command <= n_command;
            r_glyph   <= n_glyph;
            r_count   <= n_count;
            r_column  <= n_column;
            r_row     <= n_row;
            r_attr    <= n_attr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_command   = r_command;
    assign o_glyph     = r_glyph;
    assign o_count     = r_count;
    assign o_column    = r_column;
    assign o_row       = r_row;
    assign o_attr      = r_attr;

endmodule

`default_nettype wire

// ===== rtl/ansi_escape_terminal_parser_top.sv =====
// Top level of the ANSI escape sequence parser.
//
// Takes one text byte per request and gives at most one screen command per byte:
// print, newline, cursor moves, goto, clears and attribute updates (SGR). Plain
// bytes, escape bytes, digits, separators and most final bytes are handled when
// taken. The SGR final 'm' walks the parameter file from slot 0 to slot (index of
// the last parameter) through its single read port, one parameter per cycle, then
// loads the attribute result; no byte is taken during the walk. Results sit in an
// output register, so a new byte is taken while a result waits, unless stalled.
`default_nettype none

module ansi_escape_terminal_parser_top #(
    parameter int MAX_PARAMS = aetp_pkg::MAX_PARAMS_DEF,
    parameter int PARAM_BITS = aetp_pkg::PARAM_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // byte_in[7:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // glyph[7:0], repeat_count[23:8], column[40:24], row[57:41], attribute[65:58],
    // zero[71:66]
    output logic [71:0] o_m_axis_tdata,
    output logic [3:0]  o_m_axis_tuser    // command[3:0]
);
    import aetp_pkg::*;

    `include "ansi_escape_terminal_parser_top_defines.svh"

    t_dp_cmd                 dp_cmd;
    t_dp_status              dp_status;
    t_cmd                    out_command;
    logic [GLYPH_W-1:0]      out_glyph;
    logic [COUNT_W-1:0]      out_count;
    logic signed [POS_W-1:0] out_column;
    logic signed [POS_W-1:0] out_row;
    logic [ATTR_W-1:0]       out_attr;

    aetp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    aetp_dp #(
        .MAX_PARAMS (MAX_PARAMS),
        .PARAM_BITS (PARAM_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_byte      (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_command   (out_command),
        .o_glyph     (out_glyph),
        .o_count     (out_count),
        .o_column    (out_column),
        .o_row       (out_row),
        .o_attr      (out_attr)
    );

    assign o_m_axis_tuser = out_command;
    assign o_m_axis_tdata = {6'b0, out_attr, out_row, out_column, out_count, out_glyph};

    `AETP_ASSERT_SAME(a_ready_only_when_out_free, o_s_axis_tready,
        !(o_m_axis_tvalid && !i_m_axis_tready))
    `AETP_ASSERT_SAME(a_no_accept_during_walk, dp_cmd.walk_step,
        !o_s_axis_tready && !dp_cmd.accept)
    `AETP_ASSERT_NEXT(a_sgr_result_loaded, dp_cmd.walk_finish,
        o_m_axis_tvalid && o_m_axis_tuser == CMD_ATTR)

endmodule

`default_nettype wire

// ===== sim/ansi_escape_terminal_parser_top_test.sv =====
// Self-checking testbench for the ANSI escape parser top level.
`timescale 1ns / 1ps

module ansi_escape_terminal_parser_top_test;
    import aetp_pkg::*;

    localparam int NPARAM     = MAX_PARAMS_DEF;
    localparam int RAND_BYTES = 1150;
    localparam int PHASE_LEN  = 150;
    localparam int DRAIN      = 40;
    localparam int LIMIT      = 300000;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  glyph;
        logic [15:0] count;
        logic [16:0] col;
        logic [16:0] row;
        logic [7:0]  attr;
    } t_screen_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [71:0] o_m_axis_tdata;
    logic [3:0]  o_m_axis_tuser;

    // parser state mirror
    t_mode       mode = MODE_NORMAL;
    logic [15:0] pval [NPARAM];
    logic        pgiven [NPARAM];
    logic [3:0]  slot = '0;
    logic [7:0]  text_attr = ATTR_RESET;

    logic [7:0]  text_bytes [$];
    t_screen_cmd pending_cmds [$];

    int errors = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_seq = 0;
    int cycles = 0;
    int idle_phase;
    int send_idle;
    int recv_stall;

    assign idle_phase = (n_accepted / PHASE_LEN) % 4;
    assign send_idle  = (idle_phase == 1) ? 68 : (idle_phase == 3) ? 12 : 0;
    assign recv_stall = (idle_phase == 2) ? 68 : (idle_phase == 3) ? 12 : 0;

    ansi_escape_terminal_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit parse_byte(input logic [7:0] c, output t_screen_cmd r);
        logic [31:0] acc;
        logic [15:0] n;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] p;
        logic [7:0]  v;
        bit          hit;
        r = '0;
        hit = 1'b0;
        case (mode)
            MODE_ESC: begin
                mode = (c == CH_LBRK) ? MODE_CSI : MODE_NORMAL;
            end
            MODE_CSI: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    acc = 32'(pval[slot]) * 32'd10 + 32'(c - CH_ZERO);
                    pval[slot] = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
                    pgiven[slot] = 1'b1;
                end else if (c == CH_SEMI && slot != 4'(NPARAM - 1)) begin
                    slot = slot + 4'd1;
                end else begin
                    case (c)
                        CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT: begin
                            n = pgiven[0] ? pval[0] : 16'd1;
                            if (n != 0) begin
                                hit = 1'b1;
                                r.count = n;
                                r.cmd = (c == CH_UP) ? CMD_UP : (c == CH_DOWN) ? CMD_DOWN :
                                        (c == CH_RIGHT) ? CMD_RIGHT : CMD_LEFT;
                            end
                        end
                        CH_HOME, CH_HVP: begin
                            y = pgiven[0] ? pval[0] : 16'd1;
                            x = pgiven[1] ? pval[1] : 16'd1;
                            hit = 1'b1;
                            r.cmd = CMD_GOTO;
                            r.col = {1'b0, x} - 17'd1;
                            r.row = {1'b0, y} - 17'd1;
                        end
                        CH_SGR: begin
                            v = text_attr;
                            for (int i = 0; i <= slot; i++) begin
                                p = pgiven[i] ? pval[i] : 16'd0;
                                if (p == SGR_RESET) v = ATTR_RESET;
                                else if (p == SGR_BOLD) v = v | ATTR_BRIGHT;
                                else if (p == SGR_REVERSE) v = {v[3:0], v[7:4]};
                                else if (p == SGR_NORMAL) v = v & ATTR_NOBRITE;
                                else if (p == SGR_FG_DEF) v = (v & ATTR_KEEP_FG) | ATTR_RESET;
                                else if (p == SGR_BG_DEF) v = v & ATTR_LO_NIB;
                                else if (p >= SGR_FG_LO && p <= SGR_FG_HI)
                                    v = (v & ATTR_KEEP_FG) | 8'(p - SGR_FG_LO);
                                else if (p >= SGR_BG_LO && p <= SGR_BG_HI)
                                    v = (v & ATTR_KEEP_BG) | (8'(p - SGR_BG_LO) << 4);
                                else if (p >= SGR_FGB_LO && p <= SGR_FGB_HI)
                                    v = (v & ATTR_HI_NIB) | ATTR_BRIGHT | 8'(p - SGR_FGB_LO);
                                else if (p >= SGR_BGB_LO && p <= SGR_BGB_HI)
                                    v = (v & ATTR_LO_NIB) | ATTR_BG_BRT
                                        | (8'(p - SGR_BGB_LO) << 4);
                            end
                            text_attr = v;
                            hit = 1'b1;
                            r.cmd = CMD_ATTR;
                            r.attr = v;
                        end
                        CH_ED: begin
                            n = pgiven[0] ? pval[0] : 16'd0;
                            hit = 1'b1;
                            r.cmd = (n == 1) ? CMD_CLR_TO : (n == 2) ? CMD_CLR_ALL : CMD_CLR_FROM;
                        end
                        default: hit = 1'b0;
                    endcase
                    for (int i = 0; i < NPARAM; i++) begin
                        pval[i] = '0;
                        pgiven[i] = 1'b0;
                    end
                    slot = '0;
                    mode = MODE_NORMAL;
                end
            end
            default: begin
                case (c)
                    CH_BS: begin
                        hit = 1'b1;
                        r.cmd = CMD_LEFT;
                        r.count = 16'd1;
                    end
                    CH_LF: begin
                        hit = 1'b1;
                        r.cmd = CMD_NEWLINE;
                    end
                    CH_ESC: mode = MODE_ESC;
                    CH_CSI: mode = MODE_CSI;
                    default: begin
                        hit = 1'b1;
                        r.cmd = CMD_PRINT;
                        r.glyph = c;
                    end
                endcase
            end
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("cycle %0d: %s mismatch, got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    task automatic push_num(input int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (text_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
                i_s_axis_tdata <= text_bytes.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and predictor
    always @(posedge i_clk) begin
        t_screen_cmd e;
        t_screen_cmd r;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_cmds.size() == 0) begin
                    report_mismatch("unexpected result, command", o_m_axis_tuser, 0);
                end else begin
                    e = pending_cmds.pop_front();
                    n_checked++;
                    if (o_m_axis_tuser !== e.cmd)
                        report_mismatch("command", o_m_axis_tuser, e.cmd);
                    if (o_m_axis_tdata[7:0] !== e.glyph)
                        report_mismatch("glyph", o_m_axis_tdata[7:0], e.glyph);
                    if (o_m_axis_tdata[23:8] !== e.count)
                        report_mismatch("repeat_count", o_m_axis_tdata[23:8], e.count);
                    if (o_m_axis_tdata[40:24] !== e.col)
                        report_mismatch("column", o_m_axis_tdata[40:24], e.col);
                    if (o_m_axis_tdata[57:41] !== e.row)
                        report_mismatch("row", o_m_axis_tdata[57:41], e.row);
                    if (o_m_axis_tdata[65:58] !== e.attr)
                        report_mismatch("attribute", o_m_axis_tdata[65:58], e.attr);
                    if (o_m_axis_tdata[71:66] !== 6'd0)
                        report_mismatch("padding", o_m_axis_tdata[71:66], 0);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                n_accepted++;
                if (parse_byte(i_s_axis_tdata, r)) pending_cmds.push_back(r);
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, pending_cmds.size());
            $display("ansi_escape_terminal_parser_top_test: errors");
            $finish;
        end
    end

    initial begin
        int nparams;
        int code;
        logic [7:0] fin;
        logic [7:0] directed [];
        directed = '{
            8'h00, 8'hFF, CH_BS, CH_LF,
            CH_CSI, CH_UP,
            CH_CSI, CH_ZERO, CH_DOWN,
            CH_CSI, "7", "0", "0", "0", "0", CH_LEFT,
            CH_CSI, CH_ZERO, CH_HVP,
            CH_CSI, "2", CH_ED,
            CH_ESC, CH_LBRK, "1", CH_SEMI, "4", "4", CH_SEMI, CH_SEMI, "7", CH_SGR,
            CH_ESC, "x",
            CH_CSI, "z"
        };
        for (int i = 0; i < NPARAM; i++) begin
            pval[i] = '0;
            pgiven[i] = 1'b0;
        end
        foreach (directed[i]) text_bytes.push_back(directed[i]);

        while (text_bytes.size() < directed.size() + RAND_BYTES) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(7))
                            0: text_bytes.push_back(CH_BS);
                            1: text_bytes.push_back(CH_LF);
                            default: text_bytes.push_back(8'($urandom_range(255)));
                        endcase
                    end
                end
                6, 7: begin
                    // broken or cut-short sequence
                    if ($urandom_range(1)) text_bytes.push_back(CH_ESC);
                    else text_bytes.push_back(CH_CSI);
                    text_bytes.push_back(8'($urandom_range(255)));
                end
                default: begin
                    n_seq++;
                    if ($urandom_range(1)) begin
                        text_bytes.push_back(CH_ESC);
                        text_bytes.push_back(CH_LBRK);
                    end else begin
                        text_bytes.push_back(CH_CSI);
                    end
                    case ($urandom_range(10))
                        0: fin = CH_UP;
                        1: fin = CH_DOWN;
                        2: fin = CH_RIGHT;
                        3: fin = CH_LEFT;
                        4: fin = CH_HOME;
                        5: fin = CH_HVP;
                        6: fin = CH_ED;
                        7, 8, 9: fin = CH_SGR;
                        default: fin = 8'($urandom_range(255));
                    endcase
                    nparams = ($urandom_range(15) == 0) ? $urandom_range(14, 18)
                                                        : $urandom_range(0, 3);
                    for (int k = 0; k < nparams; k++) begin
                        if (k > 0) text_bytes.push_back(CH_SEMI);
                        if ($urandom_range(5) != 0) begin
                            if (fin == CH_SGR) begin
                                case ($urandom_range(11))
                                    0: code = SGR_RESET;
                                    1: code = SGR_BOLD;
                                    2: code = SGR_REVERSE;
                                    3: code = SGR_NORMAL;
                                    4: code = SGR_FG_DEF;
                                    5: code = SGR_BG_DEF;
                                    6: code = SGR_FG_LO + $urandom_range(7);
                                    7: code = SGR_BG_LO + $urandom_range(7);
                                    8: code = SGR_FGB_LO + $urandom_range(7);
                                    9: code = SGR_BGB_LO + $urandom_range(7);
                                    10: code = $urandom_range(255);
                                    default: code = $urandom_range(65000, 2000000);
                                endcase
                            end else if (fin == CH_ED) begin
                                code = $urandom_range(3);
                            end else begin
                                case ($urandom_range(7))
                                    0: code = 0;
                                    1: code = $urandom_range(65530, 70000);
                                    2: code = $urandom_range(9999999);
                                    default: code = $urandom_range(1, 40);
                                endcase
                            end
                            push_num(code);
                        end
                    end
                    text_bytes.push_back(fin);
                end
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_bytes.size() != 0 || i_s_axis_tvalid || pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d bytes incl. %0d control sequences, compared %0d screen commands",
                 n_accepted, n_seq, n_checked);
        $display("idle phases: none, sender 68%%, receiver 68%%, both 12%%");
        if (errors == 0 && pending_cmds.size() == 0) begin
            $display("ansi_escape_terminal_parser_top_test: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, pending_cmds.size());
            $display("ansi_escape_terminal_parser_top_test: errors");
        end
        $finish;
    end

endmodule
